// File: hdl/imwfe_pkg.sv
package imwfe_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int FRAC_W     = 8;
    localparam int MAX_WINDOW = 1024;
    localparam int COUNT_W    = 11;
    localparam int SUM_W      = 26;
    localparam int SQ_W       = 41;
    localparam int PEAK_W     = 32;
    localparam int FEAT_W     = 24;
    localparam int NUM_AXES   = 3;
    localparam int AXIS_W     = 2;

    localparam int IN_DATA_W  = NUM_AXES * SAMPLE_W;
    localparam int OUT_USED_W = 3 * NUM_AXES * FEAT_W + FEAT_W + COUNT_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

    // Back-end arithmetic widths
    localparam int MAG_W      = SUM_W;
    localparam int PROD_W     = COUNT_W + SQ_W;
    localparam int DIV_W      = SQ_W + 2 * FRAC_W;
    localparam int RAD_W      = PROD_W + 2 * FRAC_W;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int ROOT_CNT_W = $clog2(ROOT_W);
    localparam int MUL_CNT_W  = $clog2(COUNT_W);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_CNT_W = 2;

    // One closed window as handed from the accumulator to the feature engine
    typedef struct packed {
        logic [NUM_AXES-1:0][SUM_W-1:0] sum;
        logic [NUM_AXES-1:0][SQ_W-1:0]  sq;
        logic [PEAK_W-1:0]              peak;
        logic [COUNT_W-1:0]             count;
    } win_t;

endpackage

// File: hdl/imwfe_front.sv
module imwfe_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [imwfe_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                               s_tlast,
    output logic                               win_valid,
    input  logic                               win_ready,
    output imwfe_pkg::win_t                    win
);

    logic                                                        p_valid_reg, p_valid_next;
    logic                                                        p_last_reg;
    logic signed [imwfe_pkg::NUM_AXES-1:0][imwfe_pkg::SAMPLE_W-1:0] p_smp_reg;
    logic [imwfe_pkg::NUM_AXES-1:0][imwfe_pkg::PEAK_W-1:0]       p_sq_reg;

    logic [imwfe_pkg::NUM_AXES-1:0][imwfe_pkg::SUM_W-1:0]        sum_reg, sum_next, sum_add;
    logic [imwfe_pkg::NUM_AXES-1:0][imwfe_pkg::SQ_W-1:0]         sq_reg, sq_next, sq_add;
    logic [imwfe_pkg::PEAK_W-1:0]                                peak_reg, peak_next, peak_add;
    logic [imwfe_pkg::COUNT_W-1:0]                               cnt_reg, cnt_next, cnt_add;
    logic [imwfe_pkg::PEAK_W-1:0]                                resultant;
    logic                                                        close;
    logic                                                        fire;

    // Square stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            p_last_reg <= s_tlast;
            for (int a = 0; a < imwfe_pkg::NUM_AXES; a++)
            begin
                p_smp_reg[a] <= signed'(s_tdata[a*imwfe_pkg::SAMPLE_W +: imwfe_pkg::SAMPLE_W]);
                p_sq_reg[a]  <= imwfe_pkg::PEAK_W'(
                    signed'(s_tdata[a*imwfe_pkg::SAMPLE_W +: imwfe_pkg::SAMPLE_W]) *
                    signed'(s_tdata[a*imwfe_pkg::SAMPLE_W +: imwfe_pkg::SAMPLE_W]));
            end
        end
    end

    // Accumulate stage
    always_comb
    begin
        for (int a = 0; a < imwfe_pkg::NUM_AXES; a++)
        begin
            // Sign-extend the sample; an element select alone reads as unsigned
            sum_add[a] = sum_reg[a] + imwfe_pkg::SUM_W'(signed'(p_smp_reg[a]));
            sq_add[a]  = sq_reg[a] + imwfe_pkg::SQ_W'(p_sq_reg[a]);
        end
        resultant = p_sq_reg[0] + p_sq_reg[1] + p_sq_reg[2];
        peak_add  = (resultant > peak_reg) ? resultant : peak_reg;
        cnt_add   = cnt_reg + imwfe_pkg::COUNT_W'(1);
        close     = p_last_reg || (cnt_add == imwfe_pkg::COUNT_W'(imwfe_pkg::MAX_WINDOW));
        fire      = p_valid_reg && (!close || win_ready);
        s_tready  = !p_valid_reg || fire;
        win_valid = p_valid_reg && close;

        p_valid_next = s_tready ? s_tvalid : p_valid_reg;

        sum_next  = sum_reg;
        sq_next   = sq_reg;
        peak_next = peak_reg;
        cnt_next  = cnt_reg;
        if (fire)
        begin
            if (close)
            begin
                sum_next  = '0;
                sq_next   = '0;
                peak_next = '0;
                cnt_next  = '0;
            end
            else
            begin
                sum_next  = sum_add;
                sq_next   = sq_add;
                peak_next = peak_add;
                cnt_next  = cnt_add;
            end
        end

        win.sum   = sum_add;
        win.sq    = sq_add;
        win.peak  = peak_add;
        win.count = cnt_add;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            sq_reg   <= '0;
            peak_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            sum_reg  <= sum_next;
            sq_reg   <= sq_next;
            peak_reg <= peak_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// File: hdl/imwfe_fifo.sv
module imwfe_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  imwfe_pkg::win_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output imwfe_pkg::win_t pop_data
);

    imwfe_pkg::win_t                     mem_reg [imwfe_pkg::FIFO_DEPTH];
    logic [imwfe_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [imwfe_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [imwfe_pkg::FIFO_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                                do_push, do_pop;

    always_comb
    begin
        push_ready  = (cnt_reg != imwfe_pkg::FIFO_CNT_W'(imwfe_pkg::FIFO_DEPTH));
        pop_valid   = (cnt_reg != '0);
        pop_data    = mem_reg[rd_ptr_reg];
        do_push     = push_valid && push_ready;
        do_pop      = pop_valid && pop_ready;
        wr_ptr_next = do_push ? wr_ptr_reg + imwfe_pkg::FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + imwfe_pkg::FIFO_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + imwfe_pkg::FIFO_CNT_W'(do_push) - imwfe_pkg::FIFO_CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: hdl/imwfe_div.sv
module imwfe_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [imwfe_pkg::DIV_W-1:0]       dividend,
    input  logic [imwfe_pkg::COUNT_W-1:0]     divisor,
    output logic                              done,
    output logic [imwfe_pkg::DIV_W-1:0]       quotient,
    output logic                              rem_nonzero
);

    logic                                 busy_reg, busy_next;
    logic                                 done_reg, done_next;
    logic [imwfe_pkg::DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [imwfe_pkg::DIV_W-1:0]          num_reg, num_next;
    logic [imwfe_pkg::COUNT_W-1:0]        rem_reg, rem_next;
    logic [imwfe_pkg::COUNT_W-1:0]        den_reg, den_next;
    logic [imwfe_pkg::COUNT_W:0]          trial, diff;
    logic                                 ge;

    // Restoring division, one quotient bit per cycle
    always_comb
    begin
        trial     = {rem_reg, num_reg[imwfe_pkg::DIV_W-1]};
        ge        = trial >= {1'b0, den_reg};
        diff      = trial - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[imwfe_pkg::DIV_W-2:0], ge};
            rem_next = ge ? diff[imwfe_pkg::COUNT_W-1:0] : trial[imwfe_pkg::COUNT_W-1:0];
            cnt_next = cnt_reg + imwfe_pkg::DIV_CNT_W'(1);
            if (cnt_reg == imwfe_pkg::DIV_CNT_W'(imwfe_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        done        = done_reg;
        quotient    = num_reg;
        rem_nonzero = (rem_reg != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

endmodule

// File: hdl/imwfe_sqrt.sv
module imwfe_sqrt
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [imwfe_pkg::RAD_W-1:0]     radicand,
    output logic                            done,
    output logic [imwfe_pkg::ROOT_W-1:0]    root
);

    logic                                 busy_reg, busy_next;
    logic                                 done_reg, done_next;
    logic [imwfe_pkg::ROOT_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [imwfe_pkg::RAD_W-1:0]          rad_reg, rad_next;
    logic [imwfe_pkg::ROOT_W+1:0]         rem_reg, rem_next;
    logic [imwfe_pkg::ROOT_W-1:0]         root_reg, root_next;
    logic [imwfe_pkg::ROOT_W+1:0]         rem_sh, trial;
    logic                                 ge;

    // Digit-by-digit root, one bit pair per cycle
    always_comb
    begin
        rem_sh    = {rem_reg[imwfe_pkg::ROOT_W-1:0], rad_reg[imwfe_pkg::RAD_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        ge        = rem_sh >= trial;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[imwfe_pkg::RAD_W-3:0], 2'b00};
            rem_next  = ge ? rem_sh - trial : rem_sh;
            root_next = {root_reg[imwfe_pkg::ROOT_W-2:0], ge};
            cnt_next  = cnt_reg + imwfe_pkg::ROOT_CNT_W'(1);
            if (cnt_reg == imwfe_pkg::ROOT_CNT_W'(imwfe_pkg::ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        done = done_reg;
        root = root_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

endmodule

// File: hdl/imwfe_back.sv
module imwfe_back
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               win_valid,
    output logic                               win_pop,
    input  imwfe_pkg::win_t                    win,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [imwfe_pkg::OUT_DATA_W-1:0]   m_tdata
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_MEAN     = 4'd1;
    localparam logic [3:0] S_MUL      = 4'd2;
    localparam logic [3:0] S_SUB      = 4'd3;
    localparam logic [3:0] S_STD_ROOT = 4'd4;
    localparam logic [3:0] S_STD_DIV  = 4'd5;
    localparam logic [3:0] S_RMS_DIV  = 4'd6;
    localparam logic [3:0] S_RMS_ROOT = 4'd7;
    localparam logic [3:0] S_PEAK     = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    localparam logic [imwfe_pkg::AXIS_W-1:0] LAST_AXIS = imwfe_pkg::AXIS_W'(imwfe_pkg::NUM_AXES - 1);

    logic [3:0]                                          state_reg, state_next;
    logic [imwfe_pkg::AXIS_W-1:0]                        axis_reg, axis_next, ax;
    logic [imwfe_pkg::MUL_CNT_W-1:0]                     mcnt_reg, mcnt_next;
    logic [imwfe_pkg::PROD_W-1:0]                        acc_reg, acc_next;
    logic [imwfe_pkg::PROD_W-1:0]                        sumsq_reg, sumsq_next;
    logic [imwfe_pkg::NUM_AXES-1:0][imwfe_pkg::FEAT_W-1:0] mean_reg, mean_next;
    logic [imwfe_pkg::NUM_AXES-1:0][imwfe_pkg::FEAT_W-1:0] std_reg, std_next;
    logic [imwfe_pkg::NUM_AXES-1:0][imwfe_pkg::FEAT_W-1:0] rms_reg, rms_next;
    logic [imwfe_pkg::FEAT_W-1:0]                        peak_reg, peak_next;
    logic                                                out_valid_reg, out_valid_next;
    logic [imwfe_pkg::OUT_DATA_W-1:0]                    out_data_reg, out_data_next;

    logic [imwfe_pkg::SUM_W-1:0]                         sum_ax, sum_cur;
    logic [imwfe_pkg::MAG_W-1:0]                         mag_ax, mag_cur;
    logic [imwfe_pkg::SQ_W-1:0]                          sq_cur;
    logic [imwfe_pkg::DIV_W-1:0]                         ceil_q, mean_val;
    logic [imwfe_pkg::PROD_W-1:0]                        dev;

    logic                                                div_start, div_done, div_rnz;
    logic [imwfe_pkg::DIV_W-1:0]                         div_dividend, div_q;
    logic                                                sqrt_start, sqrt_done;
    logic [imwfe_pkg::RAD_W-1:0]                         sqrt_radicand;
    logic [imwfe_pkg::ROOT_W-1:0]                        sqrt_root;

    imwfe_div u_div
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .dividend    (div_dividend),
        .divisor     (win.count),
        .done        (div_done),
        .quotient    (div_q),
        .rem_nonzero (div_rnz)
    );

    imwfe_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_radicand),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_comb
    begin
        // Axis whose mean division starts this cycle
        if (state_reg == S_IDLE)
        begin
            ax = '0;
        end
        else if (state_reg == S_RMS_ROOT && axis_reg != LAST_AXIS)
        begin
            ax = axis_reg + imwfe_pkg::AXIS_W'(1);
        end
        else
        begin
            ax = axis_reg;
        end
        sum_ax  = win.sum[ax];
        mag_ax  = sum_ax[imwfe_pkg::SUM_W-1] ? (~sum_ax + imwfe_pkg::MAG_W'(1)) : sum_ax;
        sum_cur = win.sum[axis_reg];
        mag_cur = sum_cur[imwfe_pkg::SUM_W-1] ? (~sum_cur + imwfe_pkg::MAG_W'(1)) : sum_cur;
        sq_cur  = win.sq[axis_reg];

        // Floor of a negative quotient rounds the magnitude up
        ceil_q   = div_q + imwfe_pkg::DIV_W'(div_rnz);
        mean_val = sum_cur[imwfe_pkg::SUM_W-1] ? (~ceil_q + imwfe_pkg::DIV_W'(1)) : div_q;
        dev      = acc_reg - sumsq_reg;

        state_next     = state_reg;
        axis_next      = axis_reg;
        mcnt_next      = mcnt_reg;
        acc_next       = acc_reg;
        sumsq_next     = sumsq_reg;
        mean_next      = mean_reg;
        std_next       = std_reg;
        rms_next       = rms_reg;
        peak_next      = peak_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        win_pop        = 1'b0;
        div_start      = 1'b0;
        div_dividend   = imwfe_pkg::DIV_W'({mag_ax, {imwfe_pkg::FRAC_W{1'b0}}});
        sqrt_start     = 1'b0;
        sqrt_radicand  = {dev, {(2*imwfe_pkg::FRAC_W){1'b0}}};

        unique case (state_reg)
            S_IDLE:
            begin
                if (win_valid)
                begin
                    div_start  = 1'b1;
                    axis_next  = '0;
                    state_next = S_MEAN;
                end
            end
            S_MEAN:
            begin
                if (div_done)
                begin
                    mean_next[axis_reg] = mean_val[imwfe_pkg::FEAT_W-1:0];
                    sumsq_next = imwfe_pkg::PROD_W'(mag_cur * mag_cur);
                    acc_next   = '0;
                    mcnt_next  = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // Shift-add n * sum of squares, one bit of n per cycle
                if (win.count[mcnt_reg])
                begin
                    acc_next = acc_reg + (imwfe_pkg::PROD_W'(sq_cur) << mcnt_reg);
                end
                mcnt_next = mcnt_reg + imwfe_pkg::MUL_CNT_W'(1);
                if (mcnt_reg == imwfe_pkg::MUL_CNT_W'(imwfe_pkg::COUNT_W - 1))
                begin
                    state_next = S_SUB;
                end
            end
            S_SUB:
            begin
                sqrt_start = 1'b1;
                state_next = S_STD_ROOT;
            end
            S_STD_ROOT:
            begin
                if (sqrt_done)
                begin
                    div_start    = 1'b1;
                    div_dividend = imwfe_pkg::DIV_W'(sqrt_root);
                    state_next   = S_STD_DIV;
                end
            end
            S_STD_DIV:
            begin
                if (div_done)
                begin
                    std_next[axis_reg] = div_q[imwfe_pkg::FEAT_W-1:0];
                    div_start    = 1'b1;
                    div_dividend = {sq_cur, {(2*imwfe_pkg::FRAC_W){1'b0}}};
                    state_next   = S_RMS_DIV;
                end
            end
            S_RMS_DIV:
            begin
                if (div_done)
                begin
                    sqrt_start    = 1'b1;
                    sqrt_radicand = imwfe_pkg::RAD_W'(div_q);
                    state_next    = S_RMS_ROOT;
                end
            end
            S_RMS_ROOT:
            begin
                if (sqrt_done)
                begin
                    rms_next[axis_reg] = sqrt_root[imwfe_pkg::FEAT_W-1:0];
                    if (axis_reg == LAST_AXIS)
                    begin
                        sqrt_start    = 1'b1;
                        sqrt_radicand = imwfe_pkg::RAD_W'({win.peak,
                                                            {(2*imwfe_pkg::FRAC_W){1'b0}}});
                        state_next    = S_PEAK;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        axis_next  = ax;
                        state_next = S_MEAN;
                    end
                end
            end
            S_PEAK:
            begin
                if (sqrt_done)
                begin
                    peak_next  = sqrt_root[imwfe_pkg::FEAT_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{imwfe_pkg::OUT_PAD_W{1'b0}}, win.count, peak_reg,
                                      rms_reg[2], std_reg[2], mean_reg[2],
                                      rms_reg[1], std_reg[1], mean_reg[1],
                                      rms_reg[0], std_reg[0], mean_reg[0]};
                    win_pop        = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        m_tvalid = out_valid_reg;
        m_tdata  = out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= '0;
            mcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            mcnt_reg      <= mcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        sumsq_reg    <= sumsq_next;
        mean_reg     <= mean_next;
        std_reg      <= std_next;
        rms_reg      <= rms_next;
        peak_reg     <= peak_next;
        out_data_reg <= out_data_next;
    end

endmodule

// File: hdl/imu_window_feature_extractor.sv
// Samples: one item per cycle into the accumulator unless a closed window waits for room in
//   the queue; two register stages (square, accumulate).
// Features: the back end runs nine bit-serial divisions, seven bit-pair square roots
//   and a shift-add multiply per axis for each window.
// A two-window queue lets sampling go on while features of closed windows are computed.
// Reset: rst_n is asynchronous, active low; clears all sums, queue and output valid.
module imu_window_feature_extractor
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // x_accel[15:0], y_accel[31:16], z_accel[47:32]
    input  logic [imwfe_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // x_mean, x_std, x_rms, y_mean, y_std, y_rms, z_mean, z_std, z_rms,
    // peak_magnitude (24 bits each from bit 0), window_count[250:240], zero pad
    output logic [imwfe_pkg::OUT_DATA_W-1:0]     m_tdata
);

    // Closed window from the accumulator into the queue
    logic            acc_win_valid;
    logic            acc_win_ready;
    imwfe_pkg::win_t acc_win;

    // Head of the queue into the feature engine
    logic            q_win_valid;
    logic            q_win_pop;
    imwfe_pkg::win_t q_win;

    // Front: square each sample, accumulate, close on last or full window
    imwfe_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .win_valid (acc_win_valid),
        .win_ready (acc_win_ready),
        .win       (acc_win)
    );

    // Hold closed windows until the feature engine is free
    imwfe_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (acc_win_valid),
        .push_ready (acc_win_ready),
        .push_data  (acc_win),
        .pop_valid  (q_win_valid),
        .pop_ready  (q_win_pop),
        .pop_data   (q_win)
    );

    // Back: mean, std and rms per axis, then peak; drop the window once its result is loaded for output
    imwfe_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .win_valid (q_win_valid),
        .win_pop   (q_win_pop),
        .win       (q_win),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: hdl/imwfe_checker.sv
module imwfe_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [imwfe_pkg::OUT_DATA_W-1:0]   m_tdata
);

    logic [imwfe_pkg::COUNT_W-1:0] cnt_field;
    logic [imwfe_pkg::FEAT_W-1:0]  x_std_field;
    logic [imwfe_pkg::FEAT_W-1:0]  x_rms_field;

    assign cnt_field   = m_tdata[imwfe_pkg::OUT_USED_W-1 -: imwfe_pkg::COUNT_W];
    assign x_std_field = m_tdata[imwfe_pkg::FEAT_W +: imwfe_pkg::FEAT_W];
    assign x_rms_field = m_tdata[2*imwfe_pkg::FEAT_W +: imwfe_pkg::FEAT_W];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (cnt_field != '0) &&
                     (cnt_field <= imwfe_pkg::COUNT_W'(imwfe_pkg::MAX_WINDOW)))
        else $error("window count out of range");

    a_std_le_rms: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> x_std_field <= x_rms_field)
        else $error("x std exceeds x rms");

    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid out of reset");

endmodule

bind imu_window_feature_extractor imwfe_checker u_imwfe_checker (.*);
